// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/i2cm_pkg.sv =====
// Types and constants of the I2C master transfer sequencer.
package i2cm_pkg;

   localparam int MAX_BYTES = 256;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int LEN_W     = $clog2(MAX_BYTES + 1);
   localparam int TLEN_W    = 9;
   localparam int CSR_W     = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_EVENT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RNW    = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE         = 3'd0,
      PH_SEND_ADDRESS = 3'd1,
      PH_ACK_ADDR     = 3'd2,
      PH_SEND_DATA    = 3'd3,
      PH_RECEIVE_DATA = 3'd4,
      PH_ACK_RECV     = 3'd5,
      PH_STOPPED      = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_PENDING  = 2'd0,
      ST_SUCCESS  = 2'd1,
      ST_SEND_ERR = 2'd2,
      ST_RECV_ERR = 2'd3
   } status_type;

   typedef struct packed {
      logic              module_enable;
      logic [6:0]        target_address;
      logic [TLEN_W-1:0] transfer_length;
      logic              read_not_write;
   } cfg_type;

   typedef struct packed {
      logic       issue_start;
      logic       issue_transmit;
      logic [7:0] tx_byte;
      logic       issue_receive;
      logic       issue_ack;
      logic       ack_level;
      logic       issue_stop;
      logic       rx_valid;
      logic [7:0] rx_index;
      logic [7:0] rx_data;
      status_type transfer_status;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// ===== hdl/i2cm_ram.sv =====
// Generic single-port-write, registered-read RAM.
module i2cm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/i2cm_ctrl.sv =====
// Transfer sequencer state machine: one request in, one result out per step.
module i2cm_ctrl
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [1:0]  command,
   input  logic [7:0]  buf_index,
   input  logic [7:0]  buf_data,
   input  logic        ack_missing,
   input  logic [7:0]  rx_byte,
   input  cfg_type     cfg,
   output rsp_type     rsp,
   output mem_req_type mem_req
);

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic              read_ff, read_in;
   logic [6:0]        addr_ff, addr_in;
   status_type        status_ff, status_in;
   logic [LEN_W-1:0]  count_inc;
   logic [LEN_W-1:0]  start_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         length_ff <= '0;
         read_ff   <= 1'b0;
         addr_ff   <= '0;
         status_ff <= ST_PENDING;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         read_ff   <= read_in;
         addr_ff   <= addr_in;
         status_ff <= status_in;
      end
   end

   assign count_inc = count_ff + 1'b1;

   // lengths above the store size act as the store size
   always_comb begin
      if (32'(cfg.transfer_length) > 32'(MAX_BYTES)) begin
         start_len = LEN_W'(MAX_BYTES);
      end else begin
         start_len = LEN_W'(cfg.transfer_length);
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      read_in   = read_ff;
      addr_in   = addr_ff;
      status_in = status_ff;
      rsp       = '0;
      mem_req   = '0;
      mem_req.wr_addr = ADDR_W'(buf_index);
      mem_req.wr_data = buf_data;
      mem_req.rd_addr = count_ff[ADDR_W-1:0];

      if (accept) begin
         case (command)
            CMD_LOAD: begin
               if (32'(buf_index) < 32'(MAX_BYTES)) begin
                  mem_req.wr_en = 1'b1;
               end
            end
            CMD_START: begin
               if (phase_ff == PH_IDLE) begin
                  if (!cfg.module_enable) begin
                     status_in = cfg.read_not_write ? ST_RECV_ERR : ST_SEND_ERR;
                  end else begin
                     status_in = ST_PENDING;
                     if (start_len != '0) begin
                        length_in       = start_len;
                        read_in         = cfg.read_not_write;
                        addr_in         = cfg.target_address;
                        count_in        = '0;
                        phase_in        = PH_SEND_ADDRESS;
                        rsp.issue_start = 1'b1;
                     end
                  end
               end
            end
            CMD_EVENT: begin
               case (phase_ff)
                  PH_SEND_ADDRESS: begin
                     rsp.issue_transmit = 1'b1;
                     rsp.tx_byte        = {addr_ff, read_ff};
                     phase_in           = read_ff ? PH_ACK_ADDR : PH_SEND_DATA;
                  end
                  PH_ACK_ADDR: begin
                     if (ack_missing) begin
                        status_in      = ST_RECV_ERR;
                        phase_in       = PH_STOPPED;
                        rsp.issue_stop = 1'b1;
                     end else begin
                        rsp.issue_receive = 1'b1;
                        phase_in          = PH_ACK_RECV;
                     end
                  end
                  PH_SEND_DATA: begin
                     if (ack_missing) begin
                        status_in      = ST_SEND_ERR;
                        phase_in       = PH_STOPPED;
                        rsp.issue_stop = 1'b1;
                     end else if (count_ff < length_ff &&
                                  32'(count_ff) < 32'(MAX_BYTES)) begin
                        // byte comes from the store's registered read in stage 1
                        rsp.issue_transmit = 1'b1;
                        mem_req.rd_en      = 1'b1;
                        count_in           = count_inc;
                     end else begin
                        status_in      = ST_SUCCESS;
                        phase_in       = PH_STOPPED;
                        rsp.issue_stop = 1'b1;
                     end
                  end
                  PH_RECEIVE_DATA: begin
                     rsp.issue_receive = 1'b1;
                     phase_in          = PH_ACK_RECV;
                  end
                  PH_ACK_RECV: begin
                     rsp.rx_valid  = 1'b1;
                     rsp.rx_index  = 8'(count_ff);
                     rsp.rx_data   = rx_byte;
                     rsp.issue_ack = 1'b1;
                     count_in      = count_inc;
                     if (count_inc < length_ff) begin
                        phase_in = PH_RECEIVE_DATA;
                     end else begin
                        // last byte: NACK and stop together
                        rsp.ack_level  = 1'b1;
                        rsp.issue_stop = 1'b1;
                        status_in      = ST_SUCCESS;
                        phase_in       = PH_STOPPED;
                     end
                  end
                  PH_STOPPED: begin
                     count_in = '0;
                     phase_in = PH_IDLE;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      rsp.transfer_status = status_in;
      rsp.busy_res        = (phase_in != PH_IDLE);
   end

endmodule

// ===== hdl/i2c_master_transfer_sequencer.sv =====
// Top level of the I2C master transfer sequencer.
//
// Requests arrive on req_* (valid/ready): command 0 loads a byte into the
// write store, 1 starts a transfer with the csr_* settings, 2 reports a bus
// engine event (ack_missing, rx_byte). Every request yields exactly one
// result on rsp_* (valid/ready): the next bus action, any received byte with
// its index, the transfer status and busy flag after the step.
// Configuration is a plain write port (csr_wr_en, csr_index, csr_wdata);
// users must write it only while the block is idle; no logic enforces that.
// A result passes through stage 1 and then the output register to rsp_*.
// Throughput: one request per cycle unless the output stalls; all sequencing
// state sits in registers updated in the accept cycle, and the write store
// is a registered-read RAM, so a data-byte lookup takes the following stage.
// Reset (synchronous, active high) returns the sequencer to idle with
// status pending and clears the configuration; the write store keeps its
// contents and needs no clearing pass.
// When rsp_ready is low the output register holds; the middle stage still
// takes one more request, then req_ready drops until the output drains.
module i2c_master_transfer_sequencer
   import i2cm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [7:0]           req_buf_index,
   input  logic [7:0]           req_buf_data,
   input  logic                 req_ack_missing,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_issue_start,
   output logic                 rsp_issue_transmit,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_issue_receive,
   output logic                 rsp_issue_ack,
   output logic                 rsp_ack_level,
   output logic                 rsp_issue_stop,
   output logic                 rsp_rx_valid,
   output logic [7:0]           rsp_rx_index,
   output logic [7:0]           rsp_rx_data,
   output logic [1:0]           rsp_transfer_status,
   output logic                 rsp_busy_res,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type     cfg_ff;
   rsp_type     ctrl_rsp;
   mem_req_type mem_req;
   logic [7:0]  ram_rdata;
   logic        accept;

   // stage 1: result from the sequencer, data byte still in the RAM
   logic        s1_valid_ff;
   rsp_type     s1_rsp_ff;
   logic        s1_mem_ff;
   logic        s1_move;

   // stage 2: output register
   logic        out_valid_ff;
   rsp_type     out_rsp_ff;
   rsp_type     out_rsp_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENABLE: cfg_ff.module_enable   <= csr_wdata[0];
            CSR_TARGET: cfg_ff.target_address  <= csr_wdata[6:0];
            CSR_LENGTH: cfg_ff.transfer_length <= csr_wdata[TLEN_W-1:0];
            CSR_RNW:    cfg_ff.read_not_write  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   i2cm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_command),
      .buf_index   (req_buf_index),
      .buf_data    (req_buf_data),
      .ack_missing (req_ack_missing),
      .rx_byte     (req_rx_byte),
      .cfg         (cfg_ff),
      .rsp         (ctrl_rsp),
      .mem_req     (mem_req)
   );

   // read data holds while stage 1 stalls: no new read without an accept
   i2cm_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff <= ctrl_rsp;
         s1_mem_ff <= mem_req.rd_en;
      end
   end

   always_comb begin
      out_rsp_in = s1_rsp_ff;
      if (s1_mem_ff) begin
         out_rsp_in.tx_byte = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_issue_start     = out_rsp_ff.issue_start;
   assign rsp_issue_transmit  = out_rsp_ff.issue_transmit;
   assign rsp_tx_byte         = out_rsp_ff.tx_byte;
   assign rsp_issue_receive   = out_rsp_ff.issue_receive;
   assign rsp_issue_ack       = out_rsp_ff.issue_ack;
   assign rsp_ack_level       = out_rsp_ff.ack_level;
   assign rsp_issue_stop      = out_rsp_ff.issue_stop;
   assign rsp_rx_valid        = out_rsp_ff.rx_valid;
   assign rsp_rx_index        = out_rsp_ff.rx_index;
   assign rsp_rx_data         = out_rsp_ff.rx_data;
   assign rsp_transfer_status = out_rsp_ff.transfer_status;
   assign rsp_busy_res        = out_rsp_ff.busy_res;

endmodule

// ===== hdl/i2cm_checker.sv =====
// Port-level checks of the sequencer's result channel, bound to the top level.
`include "assert_macros.svh"

module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_issue_start,
   input logic       rsp_issue_transmit,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_issue_ack,
   input logic       rsp_ack_level,
   input logic       rsp_issue_stop,
   input logic       rsp_rx_valid,
   input logic       rsp_busy_res
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tx_byte))
   `ASSERT_SAME(a_tx_zero, clock, reset, rsp_valid && !rsp_issue_transmit, rsp_tx_byte == 8'd0)
   `ASSERT_SAME(a_rx_ack, clock, reset, rsp_valid && rsp_rx_valid, rsp_issue_ack)
   `ASSERT_SAME(a_nack_stop, clock, reset, rsp_valid && rsp_issue_ack && rsp_ack_level, rsp_issue_stop)
   `ASSERT_SAME(a_start_busy, clock, reset, rsp_valid && rsp_issue_start, rsp_busy_res)

endmodule

bind i2c_master_transfer_sequencer i2cm_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_issue_start    (rsp_issue_start),
   .rsp_issue_transmit (rsp_issue_transmit),
   .rsp_tx_byte        (rsp_tx_byte),
   .rsp_issue_ack      (rsp_issue_ack),
   .rsp_ack_level      (rsp_ack_level),
   .rsp_issue_stop     (rsp_issue_stop),
   .rsp_rx_valid       (rsp_rx_valid),
   .rsp_busy_res       (rsp_busy_res)
);
